### rtl/gn2d_pkg.sv
// Shared constants, types and functions for the 2D gradient noise point evaluator.
// Holds the permutation table, the gradient dot product and the pipeline widths.
// No dependencies.
package gn2d_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int OUT_W     = 18;
   localparam int OUT_FRAC  = 16;
   localparam int OUT_MAX   = 131071;
   localparam int OUT_MIN   = -131072;
   localparam int STAGES    = 7;

   localparam int T_W = FRAC_BITS;
   localparam int P_W = FRAC_BITS + 4;
   localparam int U_W = FRAC_BITS + 1;
   localparam int D_W = FRAC_BITS + 3;
   localparam int L_W = FRAC_BITS + 4;
   localparam int R_W = FRAC_BITS + 5;

   localparam logic [1:0] GRAD_PP = 2'd0;
   localparam logic [1:0] GRAD_NP = 2'd1;
   localparam logic [1:0] GRAD_PN = 2'd2;
   localparam logic [1:0] GRAD_NN = 2'd3;

   typedef logic [STAGES-1:0] stage_en_type;

   typedef struct packed {
      logic signed [D_W-1:0] d00;
      logic signed [D_W-1:0] d01;
      logic signed [D_W-1:0] d10;
      logic signed [D_W-1:0] d11;
   } dots_type;

   localparam logic [7:0] PERM_ROM [256] = '{
      8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13,
      8'd201, 8'd95, 8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225,
      8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
      8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148,
      8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
      8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
      8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87,
      8'd174, 8'd20, 8'd125, 8'd136, 8'd171, 8'd168, 8'd68, 8'd175,
      8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
      8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
      8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41,
      8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54,
      8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73,
      8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89, 8'd18, 8'd169,
      8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64,
      8'd52, 8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202,
      8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
      8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17,
      8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70,
      8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9,
      8'd129, 8'd22, 8'd39, 8'd253, 8'd19, 8'd98, 8'd108, 8'd110,
      8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
      8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241,
      8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
      8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157,
      8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121, 8'd50, 8'd45,
      8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141,
      8'd128, 8'd195, 8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
   };

   function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
      return PERM_ROM[idx];
   endfunction

   function automatic logic signed [D_W-1:0] grad_dot(input logic [1:0] hash,
                                                      input logic signed [D_W-1:0] dx,
                                                      input logic signed [D_W-1:0] dy);
      logic signed [D_W-1:0] dot;
      case (hash)
         GRAD_PP: dot = dx + dy;
         GRAD_NP: dot = dy - dx;
         GRAD_PN: dot = dx - dy;
         GRAD_NN: dot = -dx - dy;
         default: dot = dx + dy;
      endcase
      return dot;
   endfunction

endpackage

### rtl/gn2d_fade.sv
// Three-stage pipelined fade curve 6t^5 - 15t^4 + 10t^3 on one fraction.
// Depends on gn2d_pkg for widths and the stage enable type.
module gn2d_fade import gn2d_pkg::*; (
   input  logic               clock,
   input  stage_en_type       stage_en,
   input  logic [T_W-1:0]     frac,
   output logic [U_W-1:0]     fade
);

   localparam int W2 = 2 * FRAC_BITS;
   localparam int W4 = 2 * FRAC_BITS + 4;
   localparam int W5 = 2 * FRAC_BITS + 5;
   localparam logic [P_W-1:0] FIFTEEN_ONE = P_W'(15) << FRAC_BITS;
   localparam logic [P_W-1:0] TEN_ONE     = P_W'(10) << FRAC_BITS;
   localparam logic [W2-1:0]  HALF_2      = W2'(1) << (FRAC_BITS - 1);
   localparam logic [W4-1:0]  HALF_4      = W4'(1) << (FRAC_BITS - 1);
   localparam logic [W5-1:0]  HALF_5      = W5'(1) << (FRAC_BITS - 1);
   localparam logic [FRAC_BITS+4:0] ONE_U = (FRAC_BITS + 5)'(1) << FRAC_BITS;

   logic [P_W-1:0]        p_w;
   logic [W4-1:0]         tp_sum;
   logic [W2-1:0]         tt_sum;
   logic [P_W-1:0]        q_ff;
   logic [T_W-1:0]        t2_ff;
   logic [T_W-1:0]        t_ff;
   logic [P_W-1:0]        r_in;
   logic [W2-1:0]         t3_sum;
   logic [P_W-1:0]        r_ff;
   logic [T_W-1:0]        t3_ff;
   logic [W5-1:0]         ur_sum;
   logic [FRAC_BITS+4:0]  u_full;
   logic [U_W-1:0]        fade_in;
   logic [U_W-1:0]        fade_ff;

   always_comb begin
      p_w    = FIFTEEN_ONE - (P_W'({frac, 2'b00}) + P_W'({frac, 1'b0}));
      tp_sum = W4'(frac) * W4'(p_w) + HALF_4;
      tt_sum = W2'(frac) * W2'(frac) + HALF_2;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         q_ff  <= tp_sum[FRAC_BITS+P_W-1:FRAC_BITS];
         t2_ff <= tt_sum[W2-1:FRAC_BITS];
         t_ff  <= frac;
      end
   end

   always_comb begin
      r_in   = TEN_ONE - q_ff;
      t3_sum = W2'(t2_ff) * W2'(t_ff) + HALF_2;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         r_ff  <= r_in;
         t3_ff <= t3_sum[W2-1:FRAC_BITS];
      end
   end

   always_comb begin
      ur_sum  = W5'(t3_ff) * W5'(r_ff) + HALF_5;
      u_full  = ur_sum[W5-1:FRAC_BITS];
      fade_in = (u_full > ONE_U) ? ONE_U[U_W-1:0] : u_full[U_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         fade_ff <= fade_in;
      end
   end

   assign fade = fade_ff;

endmodule

### rtl/gn2d_hash.sv
// Three-stage corner hashing and gradient dot products for one point.
// Depends on gn2d_pkg for the permutation table, gradient function and types.
module gn2d_hash import gn2d_pkg::*; (
   input  logic                       clock,
   input  stage_en_type               stage_en,
   input  logic signed [COORD_W-1:0]  coord_x,
   input  logic signed [COORD_W-1:0]  coord_y,
   output dots_type                   dots
);

   localparam logic signed [D_W-1:0] ONE_D = D_W'(1) << FRAC_BITS;

   logic [7:0]             px0_ff;
   logic [7:0]             px1_ff;
   logic [7:0]             yi_ff;
   logic [T_W-1:0]         fx_ff;
   logic [T_W-1:0]         fy_ff;
   logic [7:0]             xi;
   logic [7:0]             xi_next;
   logic [7:0]             idx00;
   logic [7:0]             idx01;
   logic [7:0]             idx10;
   logic [7:0]             idx11;
   logic signed [D_W-1:0]  x0;
   logic signed [D_W-1:0]  x1;
   logic signed [D_W-1:0]  y0;
   logic signed [D_W-1:0]  y1;
   logic [7:0]             h00;
   logic [7:0]             h01;
   logic [7:0]             h10;
   logic [7:0]             h11;
   dots_type               dots_in;
   dots_type               dots_ff;
   dots_type               dots_d_ff;

   always_comb begin
      xi      = coord_x[FRAC_BITS+7:FRAC_BITS];
      xi_next = xi + 8'd1;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         px0_ff <= perm_lookup(xi);
         px1_ff <= perm_lookup(xi_next);
         yi_ff  <= coord_y[FRAC_BITS+7:FRAC_BITS];
         fx_ff  <= coord_x[FRAC_BITS-1:0];
         fy_ff  <= coord_y[FRAC_BITS-1:0];
      end
   end

   always_comb begin
      idx00 = px0_ff + yi_ff;
      idx01 = px0_ff + yi_ff + 8'd1;
      idx10 = px1_ff + yi_ff;
      idx11 = px1_ff + yi_ff + 8'd1;
      h00   = perm_lookup(idx00);
      h01   = perm_lookup(idx01);
      h10   = perm_lookup(idx10);
      h11   = perm_lookup(idx11);
      x0    = $signed(D_W'(fx_ff));
      y0    = $signed(D_W'(fy_ff));
      x1    = x0 - ONE_D;
      y1    = y0 - ONE_D;
      dots_in.d00 = grad_dot(h00[1:0], x0, y0);
      dots_in.d01 = grad_dot(h01[1:0], x0, y1);
      dots_in.d10 = grad_dot(h10[1:0], x1, y0);
      dots_in.d11 = grad_dot(h11[1:0], x1, y1);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         dots_ff <= dots_in;
      end
      if (stage_en[2]) begin
         dots_d_ff <= dots_ff;
      end
   end

   assign dots = dots_d_ff;

endmodule

### rtl/gn2d_blend.sv
// Four-stage bilinear blend of the corner dot products and Q1.16 output scaling.
// Depends on gn2d_pkg for widths, output limits and the stage enable type.
module gn2d_blend import gn2d_pkg::*; (
   input  logic                     clock,
   input  stage_en_type             stage_en,
   input  dots_type                 dots,
   input  logic [U_W-1:0]           fade_u,
   input  logic [U_W-1:0]           fade_v,
   output logic signed [OUT_W-1:0]  noise
);

   localparam int E_W = FRAC_BITS + 4;
   localparam int M1_W = 2 * FRAC_BITS + 6;
   localparam int M2_W = 2 * FRAC_BITS + 7;
   localparam int OUT_SHR = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
   localparam int OUT_SHL = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
   localparam int X_W = R_W + OUT_SHL + 1;
   localparam logic signed [M1_W-1:0] HALF_M1 = M1_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [M2_W-1:0] HALF_M2 = M2_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [X_W-1:0]  RND = (OUT_SHR > 0) ? X_W'(1) << (OUT_SHR - 1) : '0;
   localparam logic signed [X_W-1:0]  SAT_HI = X_W'(OUT_MAX);
   localparam logic signed [X_W-1:0]  SAT_LO = X_W'(OUT_MIN);

   logic signed [E_W-1:0]    diff_a;
   logic signed [E_W-1:0]    diff_b;
   logic signed [M1_W-1:0]   pa_in;
   logic signed [M1_W-1:0]   pb_in;
   logic signed [M1_W-1:0]   pa_ff;
   logic signed [M1_W-1:0]   pb_ff;
   logic signed [D_W-1:0]    a_ff;
   logic signed [D_W-1:0]    b_ff;
   logic [U_W-1:0]           v4_ff;
   logic signed [M1_W-1:0]   a_ext;
   logic signed [M1_W-1:0]   b_ext;
   logic signed [M1_W-1:0]   pa_rnd;
   logic signed [M1_W-1:0]   pb_rnd;
   logic signed [M1_W-1:0]   la_w;
   logic signed [M1_W-1:0]   lb_w;
   logic signed [L_W-1:0]    la_ff;
   logic signed [L_W-1:0]    lb_ff;
   logic [U_W-1:0]           v5_ff;
   logic signed [L_W:0]      dl;
   logic signed [M2_W-1:0]   pr_in;
   logic signed [M2_W-1:0]   pr_ff;
   logic signed [L_W-1:0]    l6_ff;
   logic signed [M2_W-1:0]   l6_ext;
   logic signed [M2_W-1:0]   pr_rnd;
   logic signed [M2_W-1:0]   res_w;
   logic signed [R_W-1:0]    res;
   logic signed [X_W-1:0]    res_ext;
   logic signed [X_W-1:0]    scaled;
   logic signed [X_W-1:0]    conv;
   logic signed [OUT_W-1:0]  noise_in;
   logic signed [OUT_W-1:0]  noise_ff;

   always_comb begin
      diff_a = E_W'(dots.d10) - E_W'(dots.d00);
      diff_b = E_W'(dots.d11) - E_W'(dots.d01);
      pa_in  = $signed({1'b0, fade_u}) * diff_a;
      pb_in  = $signed({1'b0, fade_u}) * diff_b;
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         a_ff  <= dots.d00;
         b_ff  <= dots.d01;
         v4_ff <= fade_v;
      end
   end

   always_comb begin
      a_ext  = M1_W'(a_ff);
      b_ext  = M1_W'(b_ff);
      pa_rnd = (pa_ff + HALF_M1) >>> FRAC_BITS;
      pb_rnd = (pb_ff + HALF_M1) >>> FRAC_BITS;
      la_w   = a_ext + pa_rnd;
      lb_w   = b_ext + pb_rnd;
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         la_ff <= la_w[L_W-1:0];
         lb_ff <= lb_w[L_W-1:0];
         v5_ff <= v4_ff;
      end
   end

   always_comb begin
      dl    = (L_W + 1)'(lb_ff) - (L_W + 1)'(la_ff);
      pr_in = $signed({1'b0, v5_ff}) * dl;
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         pr_ff <= pr_in;
         l6_ff <= la_ff;
      end
   end

   always_comb begin
      l6_ext  = M2_W'(l6_ff);
      pr_rnd  = (pr_ff + HALF_M2) >>> FRAC_BITS;
      res_w   = l6_ext + pr_rnd;
      res     = res_w[R_W-1:0];
      res_ext = X_W'(res);
      scaled  = (res_ext <<< OUT_SHL) + RND;
      conv    = scaled >>> OUT_SHR;
      if (conv > SAT_HI) begin
         noise_in = SAT_HI[OUT_W-1:0];
      end else if (conv < SAT_LO) begin
         noise_in = SAT_LO[OUT_W-1:0];
      end else begin
         noise_in = conv[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         noise_ff <= noise_in;
      end
   end

   assign noise = noise_ff;

endmodule

### rtl/gradient_noise_2d_point.sv
// Top level of the 2D gradient noise point evaluator: stage control and datapath.
// Depends on gn2d_pkg, gn2d_fade, gn2d_hash and gn2d_blend.
//
// The req channel carries one point per transaction, req_coord_x and req_coord_y,
// in signed Q15.16. The rsp channel returns one transaction per point,
// rsp_noise in signed Q1.16, in the order the points arrived.
// A transaction is taken on a rising edge where valid is high and stall is low.
// The datapath is a seven-stage pipeline; one point per cycle is taken in steady
// state while the receiver does not stall. The stage count is set by the chain
// of three multiplications in the fade curve followed by two rounded interpolation
// multiplications and the output stage.
// Each stage holds a valid bit and loads only when it is empty or the stage
// after it moves, so bubbles are squeezed out. When the receiver stalls, the
// pipeline keeps filling, and req_stall rises only once every stage holds a
// point. Reset, synchronous and active high, empties all stages; the
// block keeps no state between points.
module gradient_noise_2d_point import gn2d_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [OUT_W-1:0]  rsp_noise
);

   logic [STAGES-1:0]  valid_ff;
   stage_en_type       stage_en;
   logic [U_W-1:0]     fade_u;
   logic [U_W-1:0]     fade_v;
   dots_type           dots;

   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int i = STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[STAGES-1];

   gn2d_fade u_fade_x (
      .clock    (clock),
      .stage_en (stage_en),
      .frac     (req_coord_x[FRAC_BITS-1:0]),
      .fade     (fade_u)
   );

   gn2d_fade u_fade_y (
      .clock    (clock),
      .stage_en (stage_en),
      .frac     (req_coord_y[FRAC_BITS-1:0]),
      .fade     (fade_v)
   );

   gn2d_hash u_hash (
      .clock    (clock),
      .stage_en (stage_en),
      .coord_x  (req_coord_x),
      .coord_y  (req_coord_y),
      .dots     (dots)
   );

   gn2d_blend u_blend (
      .clock       (clock),
      .stage_en    (stage_en),
      .dots        (dots),
      .fade_u      (fade_u),
      .fade_v      (fade_v),
      .noise       (rsp_noise)
   );

`ifndef NO_ASSERTIONS
   a_no_stall_passthrough: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("Input stalled while the receiver was taking results.");

   a_last_stage_fills: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STAGES-2] && stage_en[STAGES-1]) |=> rsp_valid)
      else $error("Transaction lost between the last two stages.");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_stall && (&valid_ff)) |=> (&valid_ff) && $stable(rsp_noise))
      else $error("Full pipeline dropped a transaction under stall.");
`endif

endmodule
